// File: hdl/ast_pkg.sv
// shared types and constants of the alarm slot table
// used by every module of the block but ast_ram, and by the port checker
package ast_pkg;

  localparam int NUM_SLOTS_DEF = 8;
  localparam int MAX_RESULTS   = 8;
  localparam int FIFO_DEPTH    = 2 * MAX_RESULTS;
  localparam int FIFO_CW       = $clog2(FIFO_DEPTH + 1);
  localparam int FIRE_CW       = $clog2(MAX_RESULTS + 1);

  localparam int ID_W   = 56;
  localparam int TIME_W = 32;

  localparam logic [TIME_W-1:0] DAY_SECONDS = 32'd86400;

  typedef enum logic [1:0] {
    REQ_CREATE = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_CHECK  = 2'd2,
    REQ_UNUSED = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_UPDATED    = 3'd0,
    ST_CREATED    = 3'd1,
    ST_FULL       = 3'd2,
    ST_REMOVED    = 3'd3,
    ST_NOT_FOUND  = 3'd4,
    ST_FIRED      = 3'd5,
    ST_NONE_FIRED = 3'd6
  } status_t;

  typedef struct packed {
    status_t           status;
    logic [ID_W-1:0]   fired_id;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] due;
    logic              rep;
  } slot_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic cmp_en;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic fifo_room;
  } stat_t;

endpackage

// File: hdl/ast_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
module ast_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/ast_fifo.sv
// result queue between the slot scan and the output stream
// uses ast_pkg for the result word type
module ast_fifo #(
  parameter int DEPTH = ast_pkg::FIFO_DEPTH,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ast_pkg::result_t  push_data,
  input  logic              pop,
  output ast_pkg::result_t  head,
  output logic              not_empty,
  output logic [CW-1:0]     count
);

  ast_pkg::result_t entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;

  assign head      = entries[rd_ptr];
  assign not_empty = (count != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hdl/ast_ctrl.sv
// request sequencer: accepts a request, walks the slots, then finishes it; the unused kind is dropped without a walk
// uses ast_pkg for the command and status structs
module ast_ctrl #(
  parameter int NUM_SLOTS = ast_pkg::NUM_SLOTS_DEF,
  localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  ast_pkg::req_t     req_type,
  output logic              in_ready,
  input  ast_pkg::stat_t    stat,
  output ast_pkg::cmd_t     cmd,
  output logic [AW-1:0]     rd_addr,
  output logic [AW-1:0]     cmp_idx
);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    TAIL,
    FINISH
  } state_t;

  state_t        state;
  logic [AW-1:0] idx;
  logic          cmp_en;
  logic          accept;

  assign in_ready   = (state == IDLE) && stat.fifo_room;
  assign accept     = in_valid && in_ready;
  assign rd_addr    = idx;
  assign cmd.load   = accept;
  assign cmd.cmp_en = cmp_en;
  assign cmd.finish = (state == FINISH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= IDLE;
      idx     <= '0;
      cmp_en  <= 1'b0;
      cmp_idx <= '0;
    end else begin
      cmp_en  <= (state == SCAN);
      cmp_idx <= idx;
      case (state)
        IDLE: begin
          idx <= '0;
          if (accept && req_type != ast_pkg::REQ_UNUSED) begin
            state <= SCAN;
          end
        end
        SCAN: begin
          if (idx == AW'(NUM_SLOTS - 1)) begin
            state <= TAIL;
          end else begin
            idx <= idx + AW'(1);
          end
        end
        TAIL: begin
          state <= FINISH;
        end
        FINISH: begin
          state <= IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// File: hdl/ast_dp.sv
// slot table datapath: slot ram, occupancy bits, compare and update, result queue
// uses ast_pkg, ast_ram and ast_fifo
module ast_dp #(
  parameter int NUM_SLOTS = ast_pkg::NUM_SLOTS_DEF,
  localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ast_pkg::cmd_t               cmd,
  input  logic [AW-1:0]               rd_addr,
  input  logic [AW-1:0]               cmp_idx,
  input  ast_pkg::req_t               req_type,
  input  logic [ast_pkg::ID_W-1:0]    alarm_id,
  input  logic [ast_pkg::TIME_W-1:0]  alarm_time,
  input  logic                        repeat_flag,
  input  logic [ast_pkg::TIME_W-1:0]  now_time,
  output ast_pkg::stat_t              stat,
  output logic                        out_valid,
  input  logic                        out_ready,
  output ast_pkg::result_t            out_res
);

  localparam int CW = ast_pkg::FIFO_CW;
  localparam int FW = ast_pkg::FIRE_CW;

  ast_pkg::req_t               req_kind;
  logic [ast_pkg::ID_W-1:0]    req_id;
  logic [ast_pkg::TIME_W-1:0]  req_time;
  logic                        req_rep;
  logic [ast_pkg::TIME_W-1:0]  req_now;

  logic [NUM_SLOTS-1:0]        vbits;
  logic                        matched;
  logic                        empty_found;
  logic [AW-1:0]               empty_idx;
  logic                        pend_valid;
  logic [ast_pkg::ID_W-1:0]    pend_id;
  logic [FW-1:0]               fire_count;

  ast_pkg::slot_t              rd_slot;
  ast_pkg::slot_t              wr_slot;
  logic                        we;
  logic [AW-1:0]               waddr;
  logic                        occupied;
  logic                        hit;
  logic                        due_hit;
  logic                        id_zero;
  logic                        push;
  ast_pkg::result_t            push_data;
  logic [CW-1:0]               fifo_count;

  assign occupied = vbits[cmp_idx];
  assign id_zero  = (req_id == '0);
  assign hit      = cmd.cmp_en && occupied && (rd_slot.id == req_id);
  assign due_hit  = cmd.cmp_en && occupied && (rd_slot.due <= req_now)
                    && (fire_count < FW'(ast_pkg::MAX_RESULTS));

  assign stat.fifo_room = (fifo_count <= CW'(ast_pkg::FIFO_DEPTH - ast_pkg::MAX_RESULTS));

  ast_ram #(
    .WIDTH ($bits(ast_pkg::slot_t)),
    .DEPTH (NUM_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wr_slot),
    .raddr (rd_addr),
    .rdata (rd_slot)
  );

  ast_fifo #(
    .DEPTH (ast_pkg::FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (out_valid && out_ready),
    .head      (out_res),
    .not_empty (out_valid),
    .count     (fifo_count)
  );

  // ram writes and result pushes
  always_comb begin
    we        = 1'b0;
    waddr     = cmp_idx;
    wr_slot   = '{id: req_id, due: req_time, rep: req_rep};
    push      = 1'b0;
    push_data = '{status: ast_pkg::ST_NOT_FOUND, fired_id: '0, last: 1'b1};
    case (req_kind)
      ast_pkg::REQ_CREATE: begin
        if (hit) begin
          we = 1'b1;
        end
        if (cmd.finish) begin
          push = 1'b1;
          if (id_zero) begin
            push_data.status = ast_pkg::ST_NOT_FOUND;
          end else if (matched) begin
            push_data.status = ast_pkg::ST_UPDATED;
          end else if (empty_found) begin
            push_data.status = ast_pkg::ST_CREATED;
            we               = 1'b1;
            waddr            = empty_idx;
          end else begin
            push_data.status = ast_pkg::ST_FULL;
          end
        end
      end
      ast_pkg::REQ_REMOVE: begin
        if (cmd.finish) begin
          push             = 1'b1;
          push_data.status = (matched && !id_zero) ? ast_pkg::ST_REMOVED
                                                   : ast_pkg::ST_NOT_FOUND;
        end
      end
      ast_pkg::REQ_CHECK: begin
        if (due_hit && rd_slot.rep) begin
          we      = 1'b1;
          wr_slot = '{id: rd_slot.id, due: rd_slot.due + ast_pkg::DAY_SECONDS, rep: 1'b1};
        end
        if (due_hit && pend_valid) begin
          push      = 1'b1;
          push_data = '{status: ast_pkg::ST_FIRED, fired_id: pend_id, last: 1'b0};
        end
        if (cmd.finish) begin
          push = 1'b1;
          if (pend_valid) begin
            push_data = '{status: ast_pkg::ST_FIRED, fired_id: pend_id, last: 1'b1};
          end else begin
            push_data = '{status: ast_pkg::ST_NONE_FIRED, fired_id: '0, last: 1'b1};
          end
        end
      end
      default: begin
        we   = 1'b0;
        push = 1'b0;
      end
    endcase
  end

  // latched request word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_kind <= req_type;
      req_id   <= alarm_id;
      req_time <= alarm_time;
      req_rep  <= repeat_flag;
      req_now  <= now_time;
    end
  end

  // per request scan state and slot occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      vbits       <= '0;
      matched     <= 1'b0;
      empty_found <= 1'b0;
      empty_idx   <= '0;
      pend_valid  <= 1'b0;
      pend_id     <= '0;
      fire_count  <= '0;
    end else if (cmd.load) begin
      matched     <= 1'b0;
      empty_found <= 1'b0;
      pend_valid  <= 1'b0;
      fire_count  <= '0;
    end else begin
      case (req_kind)
        ast_pkg::REQ_CREATE: begin
          if (hit) begin
            matched <= 1'b1;
          end
          if (cmd.cmp_en && !occupied && !empty_found) begin
            empty_found <= 1'b1;
            empty_idx   <= cmp_idx;
          end
          if (cmd.finish && !id_zero && !matched && empty_found) begin
            vbits[empty_idx] <= 1'b1;
          end
        end
        ast_pkg::REQ_REMOVE: begin
          if (hit) begin
            matched        <= 1'b1;
            vbits[cmp_idx] <= 1'b0;
          end
        end
        ast_pkg::REQ_CHECK: begin
          if (due_hit) begin
            pend_valid <= 1'b1;
            pend_id    <= rd_slot.id;
            fire_count <= fire_count + FW'(1);
            if (!rd_slot.rep) begin
              vbits[cmp_idx] <= 1'b0;
            end
          end
        end
        default: begin
          matched <= matched;
        end
      endcase
    end
  end

endmodule

// File: hdl/alarm_slot_table.sv
// alarm slot table top level: stream ports, controller and datapath
// uses ast_pkg, ast_ctrl and ast_dp
//
// Requests arrive as words on the s_ group: s_tuser carries the request kind
// (create or update, remove, check), s_tdata the alarm id, due time, repeat
// flag and current time. Results leave as words on the m_ group; m_tlast
// marks the final result of a request. Create, update and remove give one
// status word. A check gives one fired word per due slot (at most MAX_RESULTS),
// in slot order, or a single none fired word.
// An accepted request walks the slots in SCAN, compares the last slot in TAIL
// and pushes its last result into the output queue in FINISH; the slot walk
// reads one slot per cycle from the slot ram. A new request is taken only back
// in IDLE and with room in the queue, while earlier results may still queue.
// Unused request kind 3 is taken and dropped without a slot walk.
// A result queue of twice the largest result burst decouples the output; a
// stalled receiver only stops new requests once the queue lacks room for a
// full burst. Reset empties every slot through per slot occupancy bits and
// flushes the queue; the block is ready in the cycle after reset.
module alarm_slot_table #(
  parameter int NUM_SLOTS = ast_pkg::NUM_SLOTS_DEF,
  localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // alarm_id, alarm_time, repeat_flag, now_time
  input  logic [1:0]   s_tuser,   // req_type
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata,   // status, fired_id
  output logic         m_tlast    // last
);

  ast_pkg::cmd_t    cmd;
  ast_pkg::stat_t   stat;
  ast_pkg::req_t    req_type;
  ast_pkg::result_t res;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    cmp_idx;

  assign req_type = ast_pkg::req_t'(s_tuser);
  assign m_tdata  = {5'b0, res.fired_id, res.status};
  assign m_tlast  = res.last;

  ast_ctrl #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .req_type (req_type),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd),
    .rd_addr  (rd_addr),
    .cmp_idx  (cmp_idx)
  );

  ast_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .rd_addr     (rd_addr),
    .cmp_idx     (cmp_idx),
    .req_type    (req_type),
    .alarm_id    (s_tdata[55:0]),
    .alarm_time  (s_tdata[87:56]),
    .repeat_flag (s_tdata[88]),
    .now_time    (s_tdata[120:89]),
    .stat        (stat),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_res     (res)
  );

endmodule

// File: hdl/ast_checker.sv
// port level checks for the alarm slot table, bound to the top level
// uses ast_pkg for request and status codes
module ast_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [1:0]   s_tuser,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [63:0]  m_tdata,
  input logic         m_tlast
);

  // output word holds while stalled
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  // queue is empty right after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // a real request keeps the input closed while the slots are walked
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser != ast_pkg::REQ_UNUSED |=> !s_tready)
    else $error("second request taken during slot walk");

  // only fired words carry an id, and every other word ends its request
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] != ast_pkg::ST_FIRED |-> m_tlast && m_tdata[58:3] == '0)
    else $error("status word without last or with nonzero id");

  // status codes above none fired never appear, and the padding bits stay zero
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2:0] != 3'd7 && m_tdata[63:59] == '0)
    else $error("bad status code or padding");

endmodule

bind alarm_slot_table ast_checker u_ast_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// File: bench/alarm_port_checker.sv
// port checker for the alarm slot table: watches both stream groups,
// keeps its own copy of the slot table and compares every result word
// depends on ast_pkg
module alarm_port_checker
  import ast_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [127:0] s_tdata,   // alarm_id, alarm_time, repeat_flag, now_time
  input  logic [1:0]   s_tuser,   // req_type
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [63:0]  m_tdata,   // status, fired_id
  input  logic         m_tlast,   // last
  output int           fail_count,
  output int           results_owed
);

  slot_t   slots [NUM_SLOTS];
  result_t owed_q [$];
  int      fails = 0;

  assign fail_count = fails;

  function automatic void apply_request(input req_t kind, input logic [ID_W-1:0] id,
                                        input logic [TIME_W-1:0] atime, input logic rep,
                                        input logic [TIME_W-1:0] now);
    status_t st;
    bit      hit;
    int      fired;
    result_t r;
    hit = 1'b0;
    fired = 0;
    case (kind)
      REQ_CREATE, REQ_REMOVE: begin
        if (id == '0) begin
          st = ST_NOT_FOUND;
        end else if (kind == REQ_CREATE) begin
          foreach (slots[i]) begin
            if (slots[i].id == id) begin
              slots[i].due = atime;
              slots[i].rep = rep;
              hit = 1'b1;
            end
          end
          if (hit) begin
            st = ST_UPDATED;
          end else begin
            st = ST_FULL;
            foreach (slots[i]) begin
              if (st == ST_FULL && slots[i].id == '0) begin
                slots[i].id  = id;
                slots[i].due = atime;
                slots[i].rep = rep;
                st = ST_CREATED;
              end
            end
          end
        end else begin
          foreach (slots[i]) begin
            if (slots[i].id == id) begin
              slots[i] = '0;
              hit = 1'b1;
            end
          end
          st = hit ? ST_REMOVED : ST_NOT_FOUND;
        end
        r.status = st;
        r.fired_id = '0;
        r.last = 1'b1;
        owed_q.push_back(r);
      end
      REQ_CHECK: begin
        foreach (slots[i]) begin
          if (fired < MAX_RESULTS && slots[i].id != '0 && slots[i].due <= now) begin
            r.status = ST_FIRED;
            r.fired_id = slots[i].id;
            r.last = 1'b0;
            owed_q.push_back(r);
            fired++;
            if (slots[i].rep) slots[i].due = slots[i].due + DAY_SECONDS;
            else slots[i] = '0;
          end
        end
        if (fired == 0) begin
          r.status = ST_NONE_FIRED;
          r.fired_id = '0;
          r.last = 1'b1;
          owed_q.push_back(r);
        end else begin
          r = owed_q.pop_back();
          r.last = 1'b1;
          owed_q.push_back(r);
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    result_t want;
    status_t got_status;
    if (rst) begin
      foreach (slots[i]) slots[i] = '0;
      owed_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got_status = status_t'(m_tdata[2:0]);
        if (owed_q.size() == 0) begin
          $error("result word with none owed: status %0d fired_id %h last %0d",
                 m_tdata[2:0], m_tdata[58:3], m_tlast);
          fails++;
        end else begin
          want = owed_q.pop_front();
          if (got_status != want.status) begin
            $error("status: expected %0d, got %0d", want.status, got_status);
            fails++;
          end
          if (m_tdata[58:3] != want.fired_id) begin
            $error("fired_id: expected %h, got %h", want.fired_id, m_tdata[58:3]);
            fails++;
          end
          if (m_tlast != want.last) begin
            $error("last: expected %0d, got %0d", want.last, m_tlast);
            fails++;
          end
        end
      end
      if (s_tvalid && s_tready)
        apply_request(req_t'(s_tuser), s_tdata[55:0], s_tdata[87:56], s_tdata[88],
                      s_tdata[120:89]);
    end
    results_owed <= owed_q.size();
  end

endmodule

// File: bench/tb_alarm_slot_table.sv
// top of the alarm slot table bench: clock, reset, request stimulus and verdict
// depends on ast_pkg, alarm_slot_table and alarm_port_checker
module tb_alarm_slot_table;
  import ast_pkg::*;

  localparam int LIMIT     = 200000;
  localparam int POOL_SIZE = 10;
  localparam int PER_PHASE = 27;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;   // alarm_id, alarm_time, repeat_flag, now_time
  logic [1:0]   s_tuser = REQ_CREATE;   // req_type
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [63:0]  m_tdata;   // status, fired_id
  logic         m_tlast;   // last

  int fail_count;
  int results_owed;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int cycles = 0;

  logic [ID_W-1:0]   id_pool [POOL_SIZE];
  logic [TIME_W-1:0] clock_base;

  always #6 clk = ~clk;

  alarm_slot_table uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  alarm_port_checker chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .fail_count(fail_count), .results_owed(results_owed)
  );

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("tb_alarm_slot_table: FAIL");
      $finish;
    end
  end

  function automatic logic [ID_W-1:0] rand_id();
    return ID_W'({$urandom, $urandom});
  endfunction

  // called at a rising edge; returns at the edge that takes the word
  task automatic send_request(input req_t kind, input logic [ID_W-1:0] id,
                              input logic [TIME_W-1:0] atime, input logic rep,
                              input logic [TIME_W-1:0] now);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {7'd0, now, rep, atime, id};
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
  endtask

  task automatic random_request(output bit counted);
    int               pick;
    logic [ID_W-1:0]  id;
    logic [TIME_W-1:0] atime;
    logic [TIME_W-1:0] now;
    pick = $urandom_range(99);
    id = id_pool[$urandom_range(POOL_SIZE - 1)];
    atime = ($urandom_range(9) == 0) ? $urandom : clock_base + $urandom_range(0, 60000);
    now = $urandom;
    counted = 1'b1;
    if (pick < 40) begin
      send_request(REQ_CREATE, id, atime, 1'($urandom_range(1)), now);
    end else if (pick < 60) begin
      send_request(REQ_REMOVE, id, atime, 1'($urandom_range(1)), now);
    end else if (pick < 90) begin
      clock_base = clock_base + $urandom_range(0, 30000);
      if ($urandom_range(9) != 0) now = clock_base;
      send_request(REQ_CHECK, rand_id(), $urandom, 1'($urandom_range(1)), now);
    end else if (pick < 95) begin
      send_request(($urandom_range(1) != 0) ? REQ_CREATE : REQ_REMOVE, '0, atime,
                   1'($urandom_range(1)), now);
    end else begin
      send_request(REQ_UNUSED, rand_id(), $urandom, 1'($urandom_range(1)), now);
      counted = 1'b0;
    end
  endtask

  initial begin
    bit counted;
    int done;
    foreach (id_pool[i]) begin
      id_pool[i] = rand_id();
      if (id_pool[i] == '0) id_pool[i] = ID_W'(i + 1);
    end
    clock_base = $urandom_range(0, 100000);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table, zero id, fill to full, update, unused kind, full burst
    send_request(REQ_CHECK, '0, '0, 1'b0, '0);
    send_request(REQ_CREATE, '0, 32'd100, 1'b1, '0);
    send_request(REQ_REMOVE, '0, '0, 1'b0, '0);
    send_request(REQ_REMOVE, 56'd5, '0, 1'b0, '0);
    send_request(REQ_CREATE, '1, '1, 1'b1, '0);
    for (int i = 1; i < 8; i++)
      send_request(REQ_CREATE, ID_W'(i), TIME_W'(i * 1000 - 1000), i[0], '1);
    send_request(REQ_CREATE, 56'd9, 32'd50, 1'b0, '0);
    send_request(REQ_CREATE, '1, 32'hFFFF_FFF0, 1'b1, '0);
    send_request(REQ_UNUSED, '1, '1, 1'b1, '1);
    send_request(REQ_CHECK, '0, '0, 1'b0, '1);
    send_request(REQ_CHECK, '0, '0, 1'b0, 32'd500);
    send_request(REQ_CHECK, '0, '0, 1'b0, 32'd90000);
    send_request(REQ_REMOVE, '1, '0, 1'b0, '0);
    send_request(REQ_REMOVE, '1, '0, 1'b0, '0);
    send_request(REQ_CHECK, '0, '0, 1'b0, '1);
    send_request(REQ_CHECK, '0, '0, 1'b0, '0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 65; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 65; end
        default: begin send_idle_pct = 11; stall_pct = 11; end
      endcase
      done = 0;
      while (done < PER_PHASE) begin
        random_request(counted);
        if (counted) done++;
      end
    end

    s_tvalid <= 1'b0;
    do @(negedge clk); while (results_owed != 0);
    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("tb_alarm_slot_table: PASS");
    else $display("tb_alarm_slot_table: FAIL");
    $finish;
  end

endmodule

// File: sim.f
hdl/ast_pkg.sv
hdl/ast_ram.sv
hdl/ast_fifo.sv
hdl/ast_ctrl.sv
hdl/ast_dp.sv
hdl/alarm_slot_table.sv
hdl/ast_checker.sv
bench/alarm_port_checker.sv
bench/tb_alarm_slot_table.sv
